@@ src/keyed_event_time_window_assert.svh @@
// assertion macros shared by the keyed event time window rtl
`ifndef KEYED_EVENT_TIME_WINDOW_ASSERT_SVH
`define KEYED_EVENT_TIME_WINDOW_ASSERT_SVH

// condition must hold in the same cycle as the trigger
`define KEWT_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("keyed_event_time_window: same-cycle check failed");

// condition must hold in the cycle after the trigger
`define KEWT_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("keyed_event_time_window: next-cycle check failed");

`endif

@@ src/kewt_pkg.sv @@
// shared types and constants of the keyed event time window
`default_nettype none

package kewt_pkg;

  localparam int KEY_COUNT_DEF    = 16;
  localparam int WINDOW_DEPTH_DEF = 64;

  localparam int KEY_W       = 4;
  localparam int STAMP_W     = 63;
  localparam int PRICE_W     = 32;
  localparam int STATUS_W    = 2;
  localparam int COUNT_W     = 7;
  localparam int SUM_W       = 38;
  localparam int MEAN_W      = 32;
  localparam int DELAY_W     = 32;
  localparam int LIMIT_W     = 7;
  localparam int CFG_INDEX_W = 1;
  localparam int CFG_DATA_W  = 32;

  localparam logic [DELAY_W-1:0] DELAY_RESET = 32'd1000000;
  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 7'd64;

  // action codes
  localparam logic ACT_INGEST = 1'b0;
  localparam logic ACT_QUERY  = 1'b1;

  // configuration register indexes
  localparam logic [CFG_INDEX_W-1:0] CFG_DELAY = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] CFG_LIMIT = 1'b1;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK      = 2'd0,
    ST_LATE    = 2'd1,
    ST_UNKNOWN = 2'd2,
    ST_NODATA  = 2'd3
  } status_t;

  // one stored sample
  typedef struct packed {
    logic [STAMP_W-1:0] ts;
    logic [PRICE_W-1:0] price;
    logic               priced;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

`default_nettype wire

@@ src/kewt_if.sv @@
// handshake channels of the keyed event time window
`default_nettype none

interface kewt_item_if;
  logic                              valid;
  logic                              ready;
  logic                              action;
  logic [kewt_pkg::KEY_W-1:0]        key_index;
  logic [kewt_pkg::STAMP_W-1:0]      stamp;
  logic signed [kewt_pkg::PRICE_W-1:0] price;
  logic                              has_price;
  modport source (output valid, action, key_index, stamp, price, has_price, input ready);
  modport sink (input valid, action, key_index, stamp, price, has_price, output ready);
endinterface

interface kewt_result_if;
  logic                               valid;
  logic                               ready;
  logic [kewt_pkg::STATUS_W-1:0]      status;
  logic [kewt_pkg::COUNT_W-1:0]       sample_count;
  logic signed [kewt_pkg::SUM_W-1:0]  price_sum;
  logic signed [kewt_pkg::MEAN_W-1:0] avg_price;
  modport source (output valid, status, sample_count, price_sum, avg_price, input ready);
  modport sink (input valid, status, sample_count, price_sum, avg_price, output ready);
endinterface

interface kewt_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [kewt_pkg::CFG_INDEX_W-1:0]  index;
  logic [kewt_pkg::CFG_DATA_W-1:0]   data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

@@ src/kewt_ram.sv @@
// generic single write port ram with registered read
`default_nettype none

module kewt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                                   clk,
  input  wire logic                                   we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                       wdata,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                            rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

@@ src/kewt_div.sv @@
// iterative signed by unsigned divider, one quotient bit per cycle
`default_nettype none

module kewt_div (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              start,
  input  wire logic signed [kewt_pkg::SUM_W-1:0] dividend,
  input  wire logic [kewt_pkg::COUNT_W-1:0]      divisor,
  output logic signed [kewt_pkg::MEAN_W-1:0]     quotient,
  output kewt_pkg::div_stat_t                    stat
);

  localparam int SW = kewt_pkg::SUM_W;
  localparam int CW = kewt_pkg::COUNT_W;
  localparam int NW = $clog2(SW + 1);

  logic [SW-1:0] mag;
  logic [CW-1:0] rem;
  logic [CW-1:0] dvs;
  logic          neg;
  logic [NW-1:0] step;
  logic          busy;
  logic          done;
  logic [CW:0]   trial;
  logic          qbit;
  logic [SW-1:0] q_full;

  // shift in the next dividend bit and try the subtract
  assign trial  = {rem, mag[SW-1]};
  assign qbit   = (trial >= {1'b0, dvs});
  assign q_full = neg ? (SW'(0) - mag) : mag;
  assign quotient = signed'(q_full[kewt_pkg::MEAN_W-1:0]);
  assign stat.busy = busy;
  assign stat.done = done;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        neg  <= dividend[SW-1];
        mag  <= dividend[SW-1] ? (SW'(0) - SW'(dividend)) : SW'(dividend);
        dvs  <= divisor;
        rem  <= '0;
        step <= NW'(SW);
        busy <= 1'b1;
      end else if (busy) begin
        rem  <= qbit ? CW'(trial - {1'b0, dvs}) : CW'(trial);
        mag  <= {mag[SW-2:0], qbit};
        step <= step - 1'b1;
        if (step == NW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

`default_nettype wire

@@ src/keyed_event_time_window.sv @@
// top level: per-key event time windows with lateness watermark and query
// Channels: item (sink) takes one beat per ingest or query, result (source)
// gives exactly one beat per item, cfg is always ready; register writes are
// to be made only while the block is idle, which the block does not enforce.
// An ingest raises the key's latest time, drops the event as late against
// the watermark, otherwise walks the key's window to find the insert place,
// trims the oldest samples to the limit and shifts the younger ones up.
// A query walks the window up to the query time summing priced samples and,
// if any were found, runs a bit-serial divide for the mean.
// One item is worked at a time over the single ram port pair, walking the
// stored samples; item ready is high only while the sequencer is idle.
// A finished result sits in the output register while the next item is
// taken; a stalled receiver holds the block only when the next result is due.
// Reset (synchronous, active high) clears all lengths, latest times and seen
// flags at once and restores the register defaults; there is no clearing pass
// since samples past a window's length are never read.
`default_nettype none
`include "keyed_event_time_window_assert.svh"

module keyed_event_time_window #(
  parameter int KEY_COUNT    = kewt_pkg::KEY_COUNT_DEF,
  parameter int WINDOW_DEPTH = kewt_pkg::WINDOW_DEPTH_DEF
) (
  input wire logic        clk,
  input wire logic        rst,
  kewt_item_if.sink       item,
  kewt_result_if.source   result,
  kewt_cfg_if.sink        cfg
);

  localparam int KW     = (KEY_COUNT > 1) ? $clog2(KEY_COUNT) : 1;
  localparam int AW     = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
  localparam int LW     = $clog2(WINDOW_DEPTH + 1);
  localparam int OW     = LW + 1;
  localparam int MDEPTH = KEY_COUNT * WINDOW_DEPTH;
  localparam int MW     = (MDEPTH > 1) ? $clog2(MDEPTH) : 1;
  localparam int TW     = kewt_pkg::STAMP_W;
  localparam int SW     = kewt_pkg::SUM_W;
  localparam int CW     = kewt_pkg::COUNT_W;

  typedef enum logic [8:0] {
    S_IDLE  = 9'b000000001,
    S_LOAD  = 9'b000000010,
    S_LATE  = 9'b000000100,
    S_SCAN  = 9'b000001000,
    S_TRIM  = 9'b000010000,
    S_SHIFT = 9'b000100000,
    S_INS   = 9'b001000000,
    S_DIV   = 9'b010000000,
    S_DONE  = 9'b100000000
  } state_t;

  // ring offset: head plus logical index, folded once into the window
  function automatic logic [AW-1:0] wrap(input logic [OW-1:0] s);
    logic [OW-1:0] t;
    t = (s >= OW'(WINDOW_DEPTH)) ? (s - OW'(WINDOW_DEPTH)) : s;
    return t[AW-1:0];
  endfunction

  state_t state;

  // configuration registers
  logic [kewt_pkg::DELAY_W-1:0] delay;
  logic [kewt_pkg::LIMIT_W-1:0] limit;

  // per-key state
  logic [LW-1:0] win_len  [KEY_COUNT];
  logic [AW-1:0] win_head [KEY_COUNT];
  logic [TW-1:0] latest   [KEY_COUNT];
  logic          seen     [KEY_COUNT];

  // latched item
  logic                   act;
  logic [KW-1:0]          kidx;
  logic [TW-1:0]          stamp_r;
  logic [kewt_pkg::PRICE_W-1:0] price_r;
  logic                   priced_r;
  logic [MW-1:0]          key_base;

  // walk state
  logic [LW-1:0] n;
  logic [AW-1:0] hd;
  logic [TW-1:0] lt;
  logic [LW-1:0] rd_i;
  logic [LW-1:0] ev_i;
  logic          pend;
  logic [LW-1:0] pos;
  logic [LW-1:0] posp;
  logic [LW-1:0] src;
  logic [LW-1:0] wj;
  logic [CW-1:0] cnt;
  logic signed [SW-1:0] sum;

  // finishing status
  kewt_pkg::status_t fin_status;
  logic              fin_ok;

  // output register
  logic                        res_valid;
  logic [kewt_pkg::STATUS_W-1:0] res_status;
  logic [CW-1:0]               res_count;
  logic signed [SW-1:0]        res_sum;
  logic signed [kewt_pkg::MEAN_W-1:0] res_mean;

  // ram
  logic                 ram_we;
  logic [MW-1:0]        ram_waddr;
  logic [MW-1:0]        ram_raddr;
  kewt_pkg::entry_t     ram_wdata;
  kewt_pkg::entry_t     ram_rdata;
  logic [LW-1:0]        rd_log;
  logic [LW-1:0]        wr_log;

  // divider
  logic                 div_start;
  logic signed [kewt_pkg::MEAN_W-1:0] div_q;
  kewt_pkg::div_stat_t  div_stat;

  // combinational helpers
  logic                 key_ok_in;
  logic [LW-1:0]        lim;
  logic [OW-1:0]        tot;
  logic [OW-1:0]        keep;
  logic [OW-1:0]        dd;
  logic                 scan_fin;
  logic [LW-1:0]        scan_pos;
  logic [TW-1:0]        lt_max;
  logic [SW-1:0]        price_ext;

  assign key_ok_in = (32'(item.key_index) < 32'(KEY_COUNT));
  assign lim       = (32'(limit) > 32'(WINDOW_DEPTH)) ? LW'(WINDOW_DEPTH) : LW'(limit);
  assign tot       = OW'(n) + OW'(1);
  assign keep      = (tot < OW'(lim)) ? tot : OW'(lim);
  assign dd        = tot - keep;
  assign lt_max    = (latest[kidx] < stamp_r) ? stamp_r : latest[kidx];
  assign price_ext = {{(SW - kewt_pkg::PRICE_W){ram_rdata.price[kewt_pkg::PRICE_W-1]}},
                      ram_rdata.price};

  // walk ends when every entry is seen or one lies past the stamp
  always_comb begin
    scan_fin = 1'b0;
    scan_pos = n;
    if (ev_i == n) begin
      scan_fin = 1'b1;
    end else if (pend && (ram_rdata.ts > stamp_r)) begin
      scan_fin = 1'b1;
      scan_pos = ev_i;
    end
  end

  // ram addressing: shift reads downward, scan reads upward
  assign rd_log    = (state == S_SHIFT) ? (src - 1'b1) : rd_i;
  assign wr_log    = (state == S_INS) ? posp : (wj + 1'b1);
  assign ram_raddr = key_base + MW'(wrap(OW'(hd) + OW'(rd_log)));
  assign ram_waddr = key_base + MW'(wrap(OW'(hd) + OW'(wr_log)));
  assign ram_we    = ((state == S_SHIFT) && pend) || (state == S_INS);
  assign ram_wdata = (state == S_INS) ? {stamp_r, price_r, priced_r} : ram_rdata;

  assign div_start = (state == S_SCAN) && scan_fin && (act == kewt_pkg::ACT_QUERY)
                     && (cnt != '0);

  assign item.ready        = (state == S_IDLE);
  assign cfg.ready         = 1'b1;
  assign result.valid      = res_valid;
  assign result.status     = res_status;
  assign result.sample_count = res_count;
  assign result.price_sum  = res_sum;
  assign result.avg_price  = res_mean;

  kewt_ram #(
    .WIDTH (kewt_pkg::ENTRY_W),
    .DEPTH (MDEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  kewt_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (sum),
    .divisor  (cnt),
    .quotient (div_q),
    .stat     (div_stat)
  );

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      delay <= kewt_pkg::DELAY_RESET;
      limit <= kewt_pkg::LIMIT_RESET;
    end else if (cfg.valid) begin
      case (cfg.index)
        kewt_pkg::CFG_DELAY: delay <= cfg.data;
        kewt_pkg::CFG_LIMIT: limit <= cfg.data[kewt_pkg::LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      res_valid <= 1'b0;
      pend      <= 1'b0;
      for (int k = 0; k < KEY_COUNT; k++) begin
        win_len[k]  <= '0;
        win_head[k] <= '0;
        latest[k]   <= '0;
        seen[k]     <= 1'b0;
      end
    end else begin
      // the finishing state reloads the output register itself
      if (result.ready && (state != S_DONE)) begin
        res_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (item.valid) begin
            act      <= item.action;
            kidx     <= KW'(item.key_index);
            stamp_r  <= item.stamp;
            price_r  <= item.price;
            priced_r <= item.has_price;
            key_base <= MW'(item.key_index) * MW'(WINDOW_DEPTH);
            fin_ok   <= 1'b0;
            if (!key_ok_in) begin
              fin_status <= kewt_pkg::ST_UNKNOWN;
              state      <= S_DONE;
            end else begin
              state <= S_LOAD;
            end
          end
        end
        S_LOAD: begin
          n    <= win_len[kidx];
          hd   <= win_head[kidx];
          rd_i <= '0;
          ev_i <= '0;
          pend <= 1'b0;
          sum  <= '0;
          cnt  <= '0;
          if (act == kewt_pkg::ACT_INGEST) begin
            lt           <= lt_max;
            latest[kidx] <= lt_max;
            seen[kidx]   <= 1'b1;
            state        <= S_LATE;
          end else if (!seen[kidx]) begin
            fin_status <= kewt_pkg::ST_UNKNOWN;
            state      <= S_DONE;
          end else begin
            state <= S_SCAN;
          end
        end
        S_LATE: begin
          // watermark below zero means nothing is late
          if ((lt >= TW'(delay)) && (stamp_r <= (lt - TW'(delay)))) begin
            fin_status <= kewt_pkg::ST_LATE;
            state      <= S_DONE;
          end else begin
            state <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (scan_fin) begin
            pos  <= scan_pos;
            pend <= 1'b0;
            if (act == kewt_pkg::ACT_INGEST) begin
              state <= S_TRIM;
            end else if (cnt == '0) begin
              fin_status <= kewt_pkg::ST_NODATA;
              state      <= S_DONE;
            end else begin
              state <= S_DIV;
            end
          end else begin
            if (rd_i < n) begin
              rd_i <= rd_i + 1'b1;
              pend <= 1'b1;
            end else begin
              pend <= 1'b0;
            end
            if (pend) begin
              ev_i <= ev_i + 1'b1;
              if ((act == kewt_pkg::ACT_QUERY) && ram_rdata.priced) begin
                sum <= sum + signed'(price_ext);
                cnt <= cnt + 1'b1;
              end
            end
          end
        end
        S_TRIM: begin
          win_len[kidx] <= LW'(keep);
          fin_status    <= kewt_pkg::ST_OK;
          if (OW'(pos) < dd) begin
            // the new sample is among the trimmed oldest ones
            win_head[kidx] <= wrap(OW'(hd) + dd - OW'(1));
            state          <= S_DONE;
          end else begin
            win_head[kidx] <= wrap(OW'(hd) + dd);
            hd             <= wrap(OW'(hd) + dd);
            posp           <= LW'(OW'(pos) - dd);
            src            <= LW'(OW'(n) - dd);
            pend           <= 1'b0;
            state          <= S_SHIFT;
          end
        end
        S_SHIFT: begin
          if (src > posp) begin
            src  <= src - 1'b1;
            wj   <= src - 1'b1;
            pend <= 1'b1;
          end else begin
            pend <= 1'b0;
            if (!pend) begin
              state <= S_INS;
            end
          end
        end
        S_INS: begin
          state <= S_DONE;
        end
        S_DIV: begin
          if (div_stat.done) begin
            fin_status <= kewt_pkg::ST_OK;
            fin_ok     <= 1'b1;
            state      <= S_DONE;
          end
        end
        S_DONE: begin
          if (!res_valid || result.ready) begin
            res_valid  <= 1'b1;
            res_status <= fin_status;
            res_count  <= fin_ok ? cnt : '0;
            res_sum    <= fin_ok ? sum : '0;
            res_mean   <= fin_ok ? div_q : '0;
            state      <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `KEWT_ASSERT_NOW(a_scan_bound, clk, rst, state == S_SCAN, (ev_i <= n) && (rd_i <= n))
  `KEWT_ASSERT_NOW(a_shift_bound, clk, rst, state == S_SHIFT, src >= posp)
  `KEWT_ASSERT_NOW(a_div_owner, clk, rst, div_stat.done, state == S_DIV)
  `KEWT_ASSERT_NOW(a_div_busy, clk, rst, div_stat.busy, state == S_DIV)
  `KEWT_ASSERT_NEXT(a_len_bound, clk, rst, state == S_LOAD, n <= LW'(WINDOW_DEPTH))

endmodule

`default_nettype wire

@@ dv/tb_top.sv @@
// testbench for the keyed event time window: directed and random ingest and query traffic
`timescale 1ns / 1ps
`default_nettype none

module tb_top;

  localparam int KEYS  = 16;
  localparam int DEPTH = 64;

  // one stored sample in the predictor
  typedef struct {
    logic [kewt_pkg::STAMP_W-1:0] ts;
    logic [kewt_pkg::PRICE_W-1:0] price;
    logic                         priced;
  } sample_t;

  // one expected result beat
  typedef struct {
    kewt_pkg::status_t             status;
    logic [kewt_pkg::COUNT_W-1:0]  count;
    logic [kewt_pkg::SUM_W-1:0]    sum;
    logic [kewt_pkg::MEAN_W-1:0]   mean;
  } answer_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  kewt_item_if   item ();
  kewt_result_if result ();
  kewt_cfg_if    cfg ();

  keyed_event_time_window dut (
    .clk    (clk),
    .rst    (rst),
    .item   (item),
    .result (result),
    .cfg    (cfg)
  );

  always #4 clk = ~clk;

  // predictor state
  logic [kewt_pkg::DELAY_W-1:0] delay_reg;
  logic [kewt_pkg::LIMIT_W-1:0] limit_reg;
  sample_t                      windows [KEYS][DEPTH];
  int unsigned                  win_len [KEYS];
  logic [kewt_pkg::STAMP_W-1:0] latest [KEYS];
  bit                           seen [KEYS];

  answer_t pending_answers [$];
  int      mismatches = 0;
  int      beats_checked = 0;
  int      ingests_sent = 0;
  int      queries_sent = 0;

  // receiver control
  bit hold_off = 1'b0;
  bit stall_on = 1'b1;

  // stamps of the current random scenario
  logic [kewt_pkg::STAMP_W-1:0] base_time [KEYS];

  task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
    $display("mismatch on %s at %0t: got %0h, expected %0h", what, $realtime, got, want);
    mismatches++;
  endtask

  // watermark check, insertion in time order and trim to the limit
  function automatic kewt_pkg::status_t ingest_predict(input int k,
                                             input logic [kewt_pkg::STAMP_W-1:0] ts,
                                             input logic [kewt_pkg::PRICE_W-1:0] pr,
                                             input logic pv);
    sample_t tmp [DEPTH+1];
    int unsigned n, pos, total, keep, lim;
    seen[k] = 1'b1;
    if (latest[k] < ts) latest[k] = ts;
    if ({1'b0, latest[k]} >= {32'd0, delay_reg} && ts <= latest[k] - delay_reg)
      return kewt_pkg::ST_LATE;
    n = win_len[k];
    pos = 0;
    while (pos < n && windows[k][pos].ts <= ts) pos++;
    for (int i = 0; i < pos; i++) tmp[i] = windows[k][i];
    tmp[pos].ts = ts;
    tmp[pos].price = pr;
    tmp[pos].priced = pv;
    for (int i = pos; i < n; i++) tmp[i+1] = windows[k][i];
    total = n + 1;
    lim = (limit_reg > DEPTH) ? DEPTH : limit_reg;
    keep = (total < lim) ? total : lim;
    for (int i = 0; i < keep; i++) windows[k][i] = tmp[total - keep + i];
    win_len[k] = keep;
    return kewt_pkg::ST_OK;
  endfunction

  // count, sum and truncated mean of priced samples up to the query time
  function automatic answer_t query_predict(input int k,
                                            input logic [kewt_pkg::STAMP_W-1:0] ts);
    answer_t a;
    longint sum;
    int cnt;
    a = '{kewt_pkg::ST_OK, '0, '0, '0};
    sum = 0;
    cnt = 0;
    if (!seen[k]) begin
      a.status = kewt_pkg::ST_UNKNOWN;
      return a;
    end
    for (int i = 0; i < win_len[k]; i++) begin
      if (windows[k][i].ts > ts) break;
      if (windows[k][i].priced) begin
        sum += longint'($signed(windows[k][i].price));
        cnt++;
      end
    end
    if (cnt == 0) begin
      a.status = kewt_pkg::ST_NODATA;
      return a;
    end
    a.count = kewt_pkg::COUNT_W'(cnt);
    a.sum = sum[kewt_pkg::SUM_W-1:0];
    a.mean = 32'(sum / cnt);
    return a;
  endfunction

  // drives one item, waits for its acceptance and records the expected beat
  task automatic send_item(input logic act, input logic [kewt_pkg::KEY_W-1:0] key,
                           input logic [kewt_pkg::STAMP_W-1:0] ts,
                           input logic [kewt_pkg::PRICE_W-1:0] pr,
                           input logic pv);
    answer_t a;
    item.valid     <= 1'b1;
    item.action    <= act;
    item.key_index <= key;
    item.stamp     <= ts;
    item.price     <= pr;
    item.has_price <= pv;
    do @(posedge clk); while (!item.ready);
    if (act == kewt_pkg::ACT_INGEST) begin
      a = '{ingest_predict(key, ts, pr, pv), '0, '0, '0};
      ingests_sent++;
    end else begin
      a = query_predict(key, ts);
      queries_sent++;
    end
    pending_answers.push_back(a);
  endtask

  task automatic idle_item();
    item.valid <= 1'b0;
  endtask

  // sender gap: lower valid for a random number of cycles
  task automatic maybe_gap();
    int g;
    if ($urandom_range(0, 5) != 0) return;
    g = $urandom_range(1, 12);
    idle_item();
    repeat (g) @(posedge clk);
  endtask

  // waits until every expected beat has arrived, plus slack
  task automatic drain();
    idle_item();
    @(posedge clk);
    while (pending_answers.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_reg(input logic [kewt_pkg::CFG_INDEX_W-1:0] idx,
                           input logic [kewt_pkg::CFG_DATA_W-1:0] val);
    cfg.valid <= 1'b1;
    cfg.index <= idx;
    cfg.data  <= val;
    do @(posedge clk); while (!cfg.ready);
    cfg.valid <= 1'b0;
    if (idx == kewt_pkg::CFG_DELAY) delay_reg = val;
    else limit_reg = val[kewt_pkg::LIMIT_W-1:0];
    @(posedge clk);
  endtask

  // result checker: compares each accepted beat with the oldest expectation
  always @(posedge clk) begin
    answer_t want;
    if (!rst && result.valid && result.ready) begin
      if (pending_answers.size() == 0) begin
        report("unexpected beat", 64'(result.status), 64'd0);
      end else begin
        want = pending_answers[0];
        pending_answers.delete(0);
        beats_checked++;
        if (result.status !== want.status)
          report("status", 64'(result.status), 64'(want.status));
        if (result.sample_count !== want.count)
          report("sample_count", 64'(result.sample_count), 64'(want.count));
        if (result.price_sum !== want.sum)
          report("price_sum", 64'(result.price_sum), 64'(want.sum));
        if (result.avg_price !== want.mean)
          report("avg_price", 64'(result.avg_price), 64'(want.mean));
      end
    end
  end

  // receiver ready: own stall pattern, plus the long hold-off when asked
  always @(posedge clk) begin
    if (rst) begin
      result.ready <= 1'b0;
    end else if (hold_off) begin
      result.ready <= 1'b0;
    end else if (!stall_on) begin
      result.ready <= 1'b1;
    end else begin
      result.ready <= ($urandom_range(0, 3) != 0);
    end
  end

  // directed: extremes, unknown key, no data, late drop, equal stamps, unpriced
  task automatic test_directed();
    logic [kewt_pkg::STAMP_W-1:0] top;
    top = '1;
    send_item(kewt_pkg::ACT_QUERY, 4'd0, 63'd5, 32'd0, 1'b0);             // unknown key
    send_item(kewt_pkg::ACT_INGEST, 4'd0, 63'd100, 32'h7FFF_FFFF, 1'b1);
    send_item(kewt_pkg::ACT_QUERY, 4'd0, 63'd99, 32'd0, 1'b0);            // no data yet
    send_item(kewt_pkg::ACT_INGEST, 4'd0, 63'd100, 32'h8000_0000, 1'b1);  // equal stamp
    send_item(kewt_pkg::ACT_INGEST, 4'd0, 63'd50, 32'h0001_0000, 1'b0);   // unpriced
    send_item(kewt_pkg::ACT_QUERY, 4'd0, 63'd100, 32'hFFFF_FFFF, 1'b1);
    send_item(kewt_pkg::ACT_INGEST, 4'd1, 63'd0, 32'hFFFF_FFFF, 1'b1);    // delay above latest
    send_item(kewt_pkg::ACT_QUERY, 4'd1, 63'd0, 32'd0, 1'b0);
    send_item(kewt_pkg::ACT_INGEST, 4'd15, top, 32'h8000_0000, 1'b1);
    send_item(kewt_pkg::ACT_INGEST, 4'd15, top - 63'd1000000, 32'd7, 1'b1); // on watermark
    send_item(kewt_pkg::ACT_INGEST, 4'd15, top - 63'd999999, 32'h8000_0000, 1'b1);
    send_item(kewt_pkg::ACT_QUERY, 4'd15, top, 32'd0, 1'b1);
    send_item(kewt_pkg::ACT_QUERY, 4'd15, 63'd0, 32'd0, 1'b1);
    for (int i = 0; i < 4; i++)
      send_item(kewt_pkg::ACT_INGEST, 4'd2, 63'(200 - i), 32'h8000_0000, 1'b1);
    send_item(kewt_pkg::ACT_QUERY, 4'd2, top, 32'd0, 1'b0);                // negative mean
    drain();
    // zero delay drops everything
    write_reg(kewt_pkg::CFG_DELAY, 32'd0);
    send_item(kewt_pkg::ACT_INGEST, 4'd3, 63'd10, 32'd1, 1'b1);
    send_item(kewt_pkg::ACT_QUERY, 4'd3, top, 32'd0, 1'b0);
    drain();
    // limit zero empties the window, then a limit above depth is written
    write_reg(kewt_pkg::CFG_DELAY, 32'hFFFF_FFFF);
    write_reg(kewt_pkg::CFG_LIMIT, 32'd0);
    send_item(kewt_pkg::ACT_INGEST, 4'd4, 63'd10, 32'd1, 1'b1);
    send_item(kewt_pkg::ACT_QUERY, 4'd4, top, 32'd0, 1'b0);
    drain();
    write_reg(kewt_pkg::CFG_LIMIT, 32'd127);
  endtask

  // one random item: mostly near the key's recent times so few are late
  task automatic random_item(input int keyspan);
    logic [kewt_pkg::KEY_W-1:0]   key;
    logic [kewt_pkg::STAMP_W-1:0] ts;
    logic [kewt_pkg::PRICE_W-1:0] pr;
    int                           mode;
    key = kewt_pkg::KEY_W'($urandom_range(0, keyspan - 1));
    mode = $urandom_range(0, 19);
    if (mode == 0)      ts = 63'({$urandom, $urandom});
    else if (mode == 1) ts = '1 - 63'($urandom_range(0, 3));
    else                ts = base_time[key] + 63'($urandom_range(0, 4000)) - 63'd1500;
    if ($urandom_range(0, 3) == 0) base_time[key] += 63'($urandom_range(0, 800));
    pr = $urandom;
    if ($urandom_range(0, 9) == 0) pr = $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
    send_item($urandom_range(0, 2) == 0 ? kewt_pkg::ACT_QUERY : kewt_pkg::ACT_INGEST,
              key, ts, pr, $urandom_range(0, 4) != 0);
    maybe_gap();
  endtask

  // random phases across several register settings
  task automatic test_random();
    logic [kewt_pkg::DELAY_W-1:0] delays [5] = '{32'd1, 32'd700, 32'd3000, 32'd1000000,
                                                 32'hFFFF_FFFF};
    logic [kewt_pkg::LIMIT_W-1:0] limits [5] = '{7'd1, 7'd5, 7'd64, 7'd17, 7'd100};
    for (int k = 0; k < KEYS; k++)
      base_time[k] = {3'($urandom_range(0, 7)), $urandom, 28'd0};
    for (int ph = 0; ph < 5; ph++) begin
      write_reg(kewt_pkg::CFG_DELAY, delays[ph]);
      write_reg(kewt_pkg::CFG_LIMIT, 32'(limits[ph]));
      stall_on = (ph != 2);
      for (int i = 0; i < 300; i++) random_item(ph == 2 ? 2 : 16);
      drain();
    end
  endtask

  // long receiver hold-off while items are sent, then a pause to empty, more items and another pause
  task automatic test_backpressure();
    fork
      begin
        hold_off = 1'b1;
        repeat (2000) @(posedge clk);
        hold_off = 1'b0;
      end
      for (int i = 0; i < 40; i++) random_item(16);
    join
    drain();
    for (int i = 0; i < 100; i++) random_item(16);
    drain();
  endtask

  initial begin
    item.valid <= 1'b0;
    item.action <= kewt_pkg::ACT_INGEST;
    item.key_index <= '0;
    item.stamp <= '0;
    item.price <= '0;
    item.has_price <= 1'b0;
    cfg.valid <= 1'b0;
    cfg.index <= kewt_pkg::CFG_DELAY;
    cfg.data <= '0;
    delay_reg = kewt_pkg::DELAY_RESET;
    limit_reg = kewt_pkg::LIMIT_RESET;
    for (int k = 0; k < KEYS; k++) begin
      win_len[k] = 0;
      latest[k] = '0;
      seen[k] = 1'b0;
    end
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_random();
    test_backpressure();
    $display("covered %0d ingests and %0d queries, %0d result beats checked",
             ingests_sent, queries_sent, beats_checked);
    $display("register settings swept include zero and full delay, limits 0 to 127");
    if (mismatches == 0 && pending_answers.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  // watchdog
  initial begin
    #20ms;
    $display("timeout");
    $display("FAILED: results differ");
    $finish;
  end

endmodule

`default_nettype wire
